/* rtl/vector_alignment_rotation_defines.svh */
// Assertion macros for the vector alignment rotation block.
// Included by the RTL files that carry concurrent assertions; depends on nothing.
`ifndef VECTOR_ALIGNMENT_ROTATION_DEFINES_SVH
`define VECTOR_ALIGNMENT_ROTATION_DEFINES_SVH
`ifndef SYNTHESIS
`define VROT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vrot assertion failed");
`define VROT_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("vrot assertion failed");
`else
`define VROT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define VROT_ASSERT_NEXT(lbl, clk, ante, cons)
`endif
`endif

/* rtl/vrot_pkg.sv */
// Shared types, constants and saturation limits for the vector alignment rotation block.
// Used by the top level and by the multiplier and divider pipelines; depends on nothing.
`default_nettype none
package vrot_pkg;
   localparam int FRAC_BITS_DEF = 14;
   localparam int LIMB = 32;
   localparam int QBITS = 16;
   localparam int MUL_LAT = 3;
   localparam int DIV_LAT = QBITS + 3;

   typedef struct packed {
      logic signed [15:0] src_x;
      logic signed [15:0] src_y;
      logic signed [15:0] src_z;
      logic signed [15:0] dst_x;
      logic signed [15:0] dst_y;
      logic signed [15:0] dst_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] r00;
      logic signed [15:0] r01;
      logic signed [15:0] r02;
      logic signed [15:0] r10;
      logic signed [15:0] r11;
      logic signed [15:0] r12;
      logic signed [15:0] r20;
      logic signed [15:0] r21;
      logic signed [15:0] r22;
      logic               degenerate;
   } rsp_type;

   function automatic int lim_pos(input int frac);
      return (frac >= 15) ? 32767 : (1 << frac);
   endfunction

   function automatic int lim_neg(input int frac);
      return (frac >= 15) ? 32768 : (1 << frac);
   endfunction
endpackage
`default_nettype wire

/* rtl/vrot_mul.sv */
// Three-stage signed multiplier built from limb partial products.
// Depends on vrot_pkg for the limb width.
`default_nettype none
module vrot_mul import vrot_pkg::*; #(
   parameter int AW = 35,
   parameter int BW = 65
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [AW-1:0]     a,
   input  logic signed [BW-1:0]     b,
   output logic signed [AW+BW-1:0]  p
);
   localparam int PW = AW + BW;
   localparam int NA = (AW + LIMB - 1) / LIMB;
   localparam int NB = (BW + LIMB - 1) / LIMB;

   logic [AW-1:0]         a_abs;
   logic [BW-1:0]         b_abs;
   logic [NA*LIMB-1:0]    a_mag;
   logic [NB*LIMB-1:0]    b_mag;
   logic [2*LIMB-1:0]     pp_in [NA*NB];
   logic [2*LIMB-1:0]     pp_ff [NA*NB];
   logic                  sgn_ff;
   logic                  sgn2_ff;
   logic [PW-1:0]         sum_in;
   logic [PW-1:0]         sum_ff;
   logic signed [PW-1:0]  p_ff;

   always_comb begin
      a_abs = a[AW-1] ? AW'(-a) : AW'(a);
      b_abs = b[BW-1] ? BW'(-b) : BW'(b);
      a_mag = (NA*LIMB)'(a_abs);
      b_mag = (NB*LIMB)'(b_abs);
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i*NB+j] = (2*LIMB)'(a_mag[i*LIMB +: LIMB]) * (2*LIMB)'(b_mag[j*LIMB +: LIMB]);
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (PW'(pp_ff[i*NB+j]) << (LIMB*(i+j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff   <= pp_in;
         sgn_ff  <= a[AW-1] ^ b[BW-1];
         sum_ff  <= sum_in;
         sgn2_ff <= sgn_ff;
         p_ff    <= sgn2_ff ? -$signed(sum_ff) : $signed(sum_ff);
      end
   end

   assign p = p_ff;
endmodule
`default_nettype wire

/* rtl/vrot_div.sv */
// Pipelined rounding divider: round(x / (n * 2^FRAC_BITS)), saturated to Q1.FRAC_BITS.
// Restoring division, one quotient bit per stage. Depends on vrot_pkg.
`default_nettype none
module vrot_div import vrot_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int XW = 131
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [XW-1:0] x,
   input  logic [63:0]          n,
   output logic signed [15:0]   q
);
   localparam int RA = XW + 1;
   localparam int RB = FRAC_BITS + 65 + QBITS;
   localparam int RW = ((RA > RB) ? RA : RB) + 1;
   localparam int LimPos = lim_pos(FRAC_BITS);
   localparam int LimNeg = lim_neg(FRAC_BITS);

   logic [XW-1:0]    m_ff;
   logic             nega_ff;
   logic [RW-1:0]    d_ff;
   logic [RW-1:0]    r_ff  [QBITS+1];
   logic [RW-1:0]    dd_ff [QBITS+1];
   logic [QBITS-1:0] q_ff  [QBITS+1];
   logic             neg_ff [QBITS+1];
   logic             ovf_ff [1:QBITS];
   logic [15:0]      qm;
   logic signed [15:0] out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff     <= x[XW-1] ? XW'(-x) : XW'(x);
         nega_ff  <= x[XW-1];
         d_ff     <= RW'(n) << FRAC_BITS;
         // Numerator 2m + d and divisor 2d give the halves-away rounding.
         r_ff[0]  <= (RW'(m_ff) << 1) + d_ff;
         dd_ff[0] <= d_ff << 1;
         q_ff[0]  <= '0;
         neg_ff[0] <= nega_ff;
      end
   end

   for (genvar s = 1; s <= QBITS; s++) begin : g_step
      localparam int K = QBITS - s;
      logic [RW-1:0] sh;
      logic          ge;
      logic          ovf_in;
      always_comb begin
         sh = dd_ff[s-1] << K;
         ge = r_ff[s-1] >= sh;
      end
      if (s == 1) begin : g_first
         // A quotient beyond the bits built here saturates whatever they hold.
         assign ovf_in = r_ff[0] >= (dd_ff[0] << QBITS);
      end else begin : g_rest
         assign ovf_in = ovf_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]   <= ge ? r_ff[s-1] - sh : r_ff[s-1];
            q_ff[s]   <= {q_ff[s-1][QBITS-2:0], ge};
            dd_ff[s]  <= dd_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            ovf_ff[s] <= ovf_in;
         end
      end
   end

   always_comb begin
      if (neg_ff[QBITS]) begin
         qm = (ovf_ff[QBITS] || (32'(q_ff[QBITS]) > LimNeg)) ? 16'(LimNeg) : q_ff[QBITS];
      end else begin
         qm = (ovf_ff[QBITS] || (32'(q_ff[QBITS]) > LimPos)) ? 16'(LimPos) : q_ff[QBITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= neg_ff[QBITS] ? -$signed(qm) : $signed(qm);
      end
   end

   assign q = out_ff;
endmodule
`default_nettype wire

/* rtl/vector_alignment_rotation.sv */
// Top level of the vector alignment rotation block: builds the rotation matrix turning a onto b.
// Depends on vrot_pkg, vrot_mul, vrot_div and the assertion macro header.
//
// The block takes one word per clock cycle unless rsp_stall holds the output word, and
// returns one matrix word per input, in order. Four stages form the dot product, cross
// product, its squares and norm; three stages of limb multipliers form the two terms of
// every entry; one stage sums them; then each of the nine entries runs through its own
// restoring divider, one quotient bit per stage, and a saturating output register.
// The whole pipeline halts only while the output word is held by rsp_stall.
`default_nettype none
`include "vector_alignment_rotation_defines.svh"
module vector_alignment_rotation import vrot_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int VW   = 34;
   localparam int BAW  = 35;
   localparam int TW   = (2*FRAC_BITS + 2 > 35) ? 2*FRAC_BITS + 3 : 36;
   localparam int VVW  = 68;
   localparam int NW   = 65;
   localparam int P1W  = BAW + NW;
   localparam int P2W  = TW + VVW;
   localparam int XW   = ((P1W > P2W) ? P1W : P2W) + 1;
   localparam int LAT  = 4 + MUL_LAT + 1 + DIV_LAT;
   localparam int ND   = MUL_LAT + 1;
   localparam int DEGL = LAT - 3;
   localparam int LimPos = lim_pos(FRAC_BITS);
   localparam int LimNeg = lim_neg(FRAC_BITS);
   localparam logic signed [TW-1:0] S2C = TW'(1) << (2*FRAC_BITS);

   logic en;
   logic vld_ff [LAT];
   req_type in_ff;

   logic signed [15:0]     av [3];
   logic signed [15:0]     bv [3];
   logic signed [31:0]     pr [3][3];
   logic signed [VW-1:0]   c_in;
   logic signed [VW-1:0]   v_in [3];
   logic signed [VW-1:0]   c_ff, c2_ff, c3_ff;
   logic signed [VW-1:0]   v_ff [3];
   logic signed [VW-1:0]   v2_ff [3];
   logic signed [VW-1:0]   v3_ff [3];
   logic signed [VVW-1:0]  vv_ff [3][3];
   logic signed [VVW-1:0]  vv3_ff [3][3];
   logic signed [TW-1:0]   t_ff, t3_ff;
   logic signed [VVW+1:0]  nsum;
   logic [63:0]            n_ff;
   logic [63:0]            nd_ff [ND];
   logic                   deg_ff [DEGL];
   logic signed [BAW-1:0]  base [3][3];
   logic signed [P1W-1:0]  p1 [3][3];
   logic signed [P2W-1:0]  p2 [3][3];
   logic signed [XW-1:0]   x_ff [3][3];
   logic signed [15:0]     qv [3][3];
   logic                   deg_out;

   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Stage one: dot and cross products.
   always_comb begin
      av[0] = in_ff.src_x; av[1] = in_ff.src_y; av[2] = in_ff.src_z;
      bv[0] = in_ff.dst_x; bv[1] = in_ff.dst_y; bv[2] = in_ff.dst_z;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pr[i][j] = av[i] * bv[j];
         end
      end
      c_in    = VW'(pr[0][0]) + VW'(pr[1][1]) + VW'(pr[2][2]);
      v_in[0] = VW'(pr[1][2]) - VW'(pr[2][1]);
      v_in[1] = VW'(pr[2][0]) - VW'(pr[0][2]);
      v_in[2] = VW'(pr[0][1]) - VW'(pr[1][0]);
   end

   assign nsum = (VVW+2)'(vv_ff[0][0]) + (VVW+2)'(vv_ff[1][1]) + (VVW+2)'(vv_ff[2][2]);

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff <= req_data;
         c_ff  <= c_in;
         v_ff  <= v_in;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               vv_ff[i][j] <= v_ff[i] * v_ff[j];
            end
         end
         c2_ff  <= c_ff;
         v2_ff  <= v_ff;
         t_ff   <= S2C - TW'(c_ff);
         n_ff   <= nsum[63:0];
         vv3_ff <= vv_ff;
         c3_ff  <= c2_ff;
         v3_ff  <= v2_ff;
         t3_ff  <= t_ff;
      end
   end

   // Cosine on the diagonal, cross-product matrix off it.
   always_comb begin
      base[0][0] = BAW'(c3_ff);
      base[1][1] = BAW'(c3_ff);
      base[2][2] = BAW'(c3_ff);
      base[0][1] = -BAW'(v3_ff[2]);
      base[0][2] =  BAW'(v3_ff[1]);
      base[1][0] =  BAW'(v3_ff[2]);
      base[1][2] = -BAW'(v3_ff[0]);
      base[2][0] = -BAW'(v3_ff[1]);
      base[2][1] =  BAW'(v3_ff[0]);
   end

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         vrot_mul #(.AW(BAW), .BW(NW)) u_mul_base (
            .clock (clock),
            .en    (en),
            .a     (base[i][j]),
            .b     ($signed({1'b0, n_ff})),
            .p     (p1[i][j])
         );
         vrot_mul #(.AW(TW), .BW(VVW)) u_mul_axis (
            .clock (clock),
            .en    (en),
            .a     (t3_ff),
            .b     (vv3_ff[i][j]),
            .p     (p2[i][j])
         );
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[i][j] <= XW'(p1[i][j]) + XW'(p2[i][j]);
            end
         end
         vrot_div #(.FRAC_BITS(FRAC_BITS), .XW(XW)) u_div (
            .clock (clock),
            .en    (en),
            .x     (x_ff[i][j]),
            .n     (nd_ff[ND-1]),
            .q     (qv[i][j])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nd_ff[0]  <= n_ff;
         for (int k = 1; k < ND; k++) begin
            nd_ff[k] <= nd_ff[k-1];
         end
         // A zero cross product means parallel or zero vectors: identity goes out.
         deg_ff[0] <= (nsum[63:0] == 64'd0);
         for (int k = 1; k < DEGL; k++) begin
            deg_ff[k] <= deg_ff[k-1];
         end
      end
   end

   assign deg_out = deg_ff[DEGL-1];

   always_comb begin
      rsp_data.degenerate = deg_out;
      rsp_data.r00 = deg_out ? 16'(LimPos) : qv[0][0];
      rsp_data.r01 = deg_out ? 16'd0       : qv[0][1];
      rsp_data.r02 = deg_out ? 16'd0       : qv[0][2];
      rsp_data.r10 = deg_out ? 16'd0       : qv[1][0];
      rsp_data.r11 = deg_out ? 16'(LimPos) : qv[1][1];
      rsp_data.r12 = deg_out ? 16'd0       : qv[1][2];
      rsp_data.r20 = deg_out ? 16'd0       : qv[2][0];
      rsp_data.r21 = deg_out ? 16'd0       : qv[2][1];
      rsp_data.r22 = deg_out ? 16'(LimPos) : qv[2][2];
   end

   `VROT_ASSERT_NEXT(a_reset_empties, clock, reset, !rsp_valid)
   `VROT_ASSERT_IMP(a_r00_range, clock, reset, rsp_valid, ($signed(rsp_data.r00) <= LimPos) && ($signed(rsp_data.r00) >= -LimNeg))
   `VROT_ASSERT_IMP(a_r11_range, clock, reset, rsp_valid, ($signed(rsp_data.r11) <= LimPos) && ($signed(rsp_data.r11) >= -LimNeg))
   `VROT_ASSERT_IMP(a_r21_range, clock, reset, rsp_valid, ($signed(rsp_data.r21) <= LimPos) && ($signed(rsp_data.r21) >= -LimNeg))
endmodule
`default_nettype wire

/* tb/sv/tb_vector_alignment_rotation.sv */
// Self-checking testbench for vector_alignment_rotation: directed table, then random vector pairs.
// Depends on vrot_pkg for the word types; results are checked against an exact rational predictor.
`timescale 1ns / 1ps
module tb_vector_alignment_rotation;
   import vrot_pkg::*;

   localparam int N_RANDOM   = 1530;
   localparam int CALM_ITEMS = 200;
   localparam int CYCLE_CAP  = 400000;
   localparam int DRAIN      = 60;
   localparam logic signed [15:0] ONE = 16'sd16384;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type matrix_queue[$];
   int      fail_count = 0;
   int      words_sent = 0;
   int      words_seen = 0;
   int      degenerate_seen = 0;
   int      cycle_count = 0;
   bit      calm = 1'b0;

   typedef struct {
      req_type vec;
      bit      typed;
      rsp_type want;
   } row_type;

   vector_alignment_rotation u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Each entry is round(X / (n * 2^14)) with X = base * n + (1 - cos) * v_i * v_j,
   // taken exactly in wide integers, halves away from zero, then clamped.
   function automatic rsp_type predict_rotation(req_type w);
      logic signed [127:0] a[3], b[3], v[3], sk[3][3];
      logic signed [127:0] c, n, s2, x, m, d, q;
      logic [15:0] e[9];
      bit neg;
      int i, j;
      a[0] = w.src_x; a[1] = w.src_y; a[2] = w.src_z;
      b[0] = w.dst_x; b[1] = w.dst_y; b[2] = w.dst_z;
      c = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      v[0] = a[1] * b[2] - a[2] * b[1];
      v[1] = a[2] * b[0] - a[0] * b[2];
      v[2] = a[0] * b[1] - a[1] * b[0];
      n = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      if (n == 0) begin
         for (i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? ONE : 16'sd0;
         return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], 1'b1};
      end
      sk[0][0] = 0;     sk[0][1] = -v[2]; sk[0][2] = v[1];
      sk[1][0] = v[2];  sk[1][1] = 0;     sk[1][2] = -v[0];
      sk[2][0] = -v[1]; sk[2][1] = v[0];  sk[2][2] = 0;
      s2 = 128'sd1 <<< 28;
      for (i = 0; i < 3; i++) begin
         for (j = 0; j < 3; j++) begin
            x = ((i == j ? c : 128'sd0) + sk[i][j]) * n + (s2 - c) * v[i] * v[j];
            neg = x < 0;
            m = neg ? -x : x;
            d = n <<< 14;
            q = (2 * m + d) / (2 * d);
            if (q > 16384) q = 16384;
            e[i * 3 + j] = neg ? -q[15:0] : q[15:0];
         end
      end
      return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], 1'b0};
   endfunction

   function automatic req_type pair(int ax, int ay, int az, int bx, int by, int bz);
      req_type w;
      w.src_x = 16'(ax); w.src_y = 16'(ay); w.src_z = 16'(az);
      w.dst_x = 16'(bx); w.dst_y = 16'(by); w.dst_z = 16'(bz);
      return w;
   endfunction

   function automatic rsp_type matrix(int m00, int m01, int m02, int m10, int m11, int m12,
                                      int m20, int m21, int m22, bit deg);
      rsp_type r;
      r.r00 = 16'(m00); r.r01 = 16'(m01); r.r02 = 16'(m02);
      r.r10 = 16'(m10); r.r11 = 16'(m11); r.r12 = 16'(m12);
      r.r20 = 16'(m20); r.r21 = 16'(m21); r.r22 = 16'(m22);
      r.degenerate = deg;
      return r;
   endfunction

   // A random unit vector rounded to Q1.14.
   function automatic void unit_vector(output int vx, output int vy, output int vz);
      real x, y, z, len;
      do begin
         x = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
         y = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
         z = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
         len = $sqrt(x * x + y * y + z * z);
      end while (len < 0.05);
      vx = $rtoi(x / len * 16384.0 + (x >= 0 ? 0.5 : -0.5));
      vy = $rtoi(y / len * 16384.0 + (y >= 0 ? 0.5 : -0.5));
      vz = $rtoi(z / len * 16384.0 + (z >= 0 ? 0.5 : -0.5));
   endfunction

   function automatic int clamp(int v);
      return v > 16384 ? 16384 : (v < -16384 ? -16384 : v);
   endfunction

   function automatic req_type random_pair();
      int ax, ay, az, bx, by, bz, sel, k;
      sel = $urandom_range(0, 99);
      unit_vector(ax, ay, az);
      unit_vector(bx, by, bz);
      if (sel < 10) begin
         k = $urandom_range(0, 1) ? 1 : -1;
         bx = k * ax; by = k * ay; bz = k * az;
      end else if (sel < 20) begin
         bx = clamp(ax + $urandom_range(0, 6) - 3);
         by = clamp(ay + $urandom_range(0, 6) - 3);
         bz = clamp(az + $urandom_range(0, 6) - 3);
      end else if (sel < 32) begin
         ax = $urandom_range(0, 32768) - 16384; ay = $urandom_range(0, 32768) - 16384;
         az = $urandom_range(0, 32768) - 16384; bx = $urandom_range(0, 32768) - 16384;
         by = $urandom_range(0, 32768) - 16384; bz = $urandom_range(0, 32768) - 16384;
      end
      return pair(ax, ay, az, bx, by, bz);
   endfunction

   task automatic send_word(req_type w, rsp_type want);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      matrix_queue.insert(matrix_queue.size(), want);
      words_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (rsp_data.degenerate) degenerate_seen++;
         if (matrix_queue.size() == 0) begin
            $error("unexpected result word");
            fail_count++;
         end else begin
            check_matrix(matrix_queue.pop_front(), rsp_data);
         end
      end
   end

   task automatic check_matrix(rsp_type want, rsp_type got);
      string names[9] = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};
      logic signed [15:0] ew, ag;
      int i;
      for (i = 0; i < 9; i++) begin
         ew = want[144 - 16 * i -: 16];
         ag = got[144 - 16 * i -: 16];
         if (ew !== ag) begin
            $error("%s expected %0d actual %0d", names[i], ew, ag);
            fail_count++;
         end
      end
      if (want.degenerate !== got.degenerate) begin
         $error("degenerate expected %0b actual %0b", want.degenerate, got.degenerate);
         fail_count++;
      end
   endtask

   // Receiver: random stall bursts, one long hold-off to back the pipeline up.
   initial begin
      bit held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (!held && words_sent >= 300) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin
      row_type rows[$];
      row_type row;
      req_type w;
      int i;

      rows.insert(rows.size(), '{pair(16384, 0, 0, 0, 16384, 0), 1,
                  matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 16384, 0)});
      rows.insert(rows.size(), '{pair(0, 16384, 0, 0, 0, 16384), 1,
                  matrix(16384, 0, 0, 0, 0, -16384, 0, 16384, 0, 0)});
      rows.insert(rows.size(), '{pair(16384, 0, 0, 16384, 0, 0), 1,
                  matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1)});
      rows.insert(rows.size(), '{pair(-16384, -16384, -16384, 16384, 16384, 16384), 1,
                  matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1)});
      rows.insert(rows.size(), '{pair(0, 0, 0, 16384, -16384, 0), 1,
                  matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1)});
      rows.insert(rows.size(), '{pair(0, 0, 0, 0, 0, 0), 1,
                  matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1)});
      rows.insert(rows.size(), '{pair(5, 7, -3, 10, 14, -6), 1,
                  matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1)});
      rows.insert(rows.size(), '{pair(16384, 16384, 16384, -16384, 16384, -16384), 0, '0});
      rows.insert(rows.size(), '{pair(-16384, 16384, -16384, 16384, -16384, -16384), 0, '0});
      rows.insert(rows.size(), '{pair(16384, 0, 0, -16384, 1, 0), 0, '0});
      rows.insert(rows.size(), '{pair(16384, 0, 0, 16384, 1, 0), 0, '0});
      rows.insert(rows.size(), '{pair(16384, 16384, 0, 0, 16384, 16384), 0, '0});
      rows.insert(rows.size(), '{pair(11585, 11585, 0, 0, 11585, 11585), 0, '0});
      rows.insert(rows.size(), '{pair(9459, 9459, 9459, -9459, 9459, 9459), 0, '0});
      rows.insert(rows.size(), '{pair(1, 0, 0, 0, 0, 1), 0, '0});
      rows.insert(rows.size(), '{pair(-1, -1, -1, 1, -1, 1), 0, '0});
      rows.insert(rows.size(), '{pair(16383, -16383, 5461, -5461, 10923, -16383), 0, '0});
      rows.insert(rows.size(), '{pair(0, 0, -16384, 0, 11585, -11585), 0, '0});
      // Full-scale inputs well beyond unit length drive the entries into saturation.
      rows.insert(rows.size(), '{pair(-32768, 0, 0, 0, -32768, 0), 0, '0});
      rows.insert(rows.size(), '{pair(-32768, 32767, -32768, 32767, -32768, -32768), 0, '0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         row = rows[i];
         send_word(row.vec, row.typed ? row.want : predict_rotation(row.vec));
      end
      for (i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM - CALM_ITEMS) calm = 1'b1;
         w = random_pair();
         send_word(w, predict_rotation(w));
      end
      req_valid <= 1'b0;

      while (matrix_queue.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("Sent %0d vector pairs (%0d directed), checked %0d matrices, %0d degenerate.",
               words_sent, rows.size(), words_seen, degenerate_seen);
      if (fail_count == 0 && matrix_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

/* sim.f */
+incdir+rtl
rtl/vrot_pkg.sv
rtl/vrot_mul.sv
rtl/vrot_div.sv
rtl/vector_alignment_rotation.sv
tb/sv/tb_vector_alignment_rotation.sv
